// ===== hw/rtl/mlp_pkg.sv =====
package mlp_pkg;

    localparam int MAX_WIDTH  = 16;
    localparam int MAX_LAYERS = 4;
    localparam int SLOTS      = MAX_WIDTH + 1;
    localparam int WMEM_DEPTH = MAX_LAYERS * MAX_WIDTH * SLOTS;
    localparam int WADDR_W    = $clog2(WMEM_DEPTH);
    localparam int ROM_DEPTH  = 256;

    // Configuration register indexes.
    localparam logic [2:0] REG_INPUT_COUNT = 3'd0;
    localparam logic [2:0] REG_LAYER_COUNT = 3'd1;
    localparam logic [2:0] REG_SIZE_0      = 3'd2;
    localparam logic [2:0] REG_SIZE_1      = 3'd3;
    localparam logic [2:0] REG_SIZE_2      = 3'd4;
    localparam logic [2:0] REG_SIZE_3      = 3'd5;
    localparam logic [2:0] REG_BIAS        = 3'd6;
    localparam logic [2:0] REG_RESP_INV    = 3'd7;

    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_INPUT  = 1'b1;

    // Unsigned long division by shift and subtract; used only while building the table.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-t) in Q.31 for t in Q.24, series on t/256 followed by eight squarings.
    function automatic logic [63:0] exp_neg(input logic [63:0] t);
        logic [63:0] one;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] u3;
        logic [63:0] u4;
        logic [63:0] e;
        one = 64'd1 << 31;
        u   = t >> 1;
        u2  = (u * u) >> 31;
        u3  = (u2 * u) >> 31;
        u4  = (u3 * u) >> 31;
        e   = one - u + (u2 >> 1) - udiv64(u3, 64'd6) + udiv64(u4, 64'd24);
        for (int k = 0; k < 8; k++) begin
            e = (e * e) >> 31;
        end
        return e;
    endfunction

    // Sigmoid table entry for one index; evaluated at elaboration only.
    function automatic logic [15:0] sig_entry(input int idx);
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] r;
        longint      zi;
        zi = -(longint'(1) <<< 27) + ((longint'(1) <<< 28) * idx) / ROM_DEPTH;
        t  = (zi < 0) ? 64'(-zi) : 64'(zi);
        e  = exp_neg(t);
        d  = (64'd1 << 31) + e;
        if (zi >= 0) begin
            r = udiv64((64'd1 << 47) + (d >> 1), d);
        end else begin
            r = udiv64((e << 16) + (d >> 1), d);
        end
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    typedef logic [15:0] rom_t [ROM_DEPTH];

    function automatic rom_t build_rom();
        rom_t rom;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[i] = sig_entry(i);
        end
        return rom;
    endfunction

    localparam rom_t SIG_ROM = build_rom();

endpackage

// ===== hw/rtl/mlp_sigmoid_inference.sv =====
// Channel  | Direction | Carries
// s_axis   | in        | tdata: value[15:0]; tuser: op, layer_index, neuron_index, weight_slot
// cfg      | in        | cfg_index, cfg_data: one configuration register
// m_axis   | out       | tdata: output_value, output_index; tuser: status; tlast: last_output
// A weight item, or an input item without last, passes a busy state before another is taken.
// The final input runs one shared multiply-accumulate over weight memory: per neuron
// fan-in + 1 products (read, multiply, add each), then scale, shift, lookup and write-back.
// Results leave through one output register; the walk stalls while it is full.
// aresetn is synchronous and clears control state only; memories are not cleared.
module mlp_sigmoid_inference (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // value[15:0]
    input  logic [11:0] s_axis_tuser,   // op[0], layer_index[2:1], neuron_index[6:3],
                                        // weight_slot[11:7]
    input  logic        s_axis_tlast,   // last_input
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // output_value[15:0], output_index[19:16], zero pad
    output logic        m_axis_tuser,   // status[0]
    output logic        m_axis_tlast    // last_output
);
    import mlp_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD    = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_ACC   = 4'd3;
    localparam logic [3:0] ST_SCALE = 4'd4;
    localparam logic [3:0] ST_ZSH   = 4'd5;
    localparam logic [3:0] ST_ROM   = 4'd6;
    localparam logic [3:0] ST_WB    = 4'd7;
    localparam logic [3:0] ST_OUTRD = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;
    localparam logic [3:0] ST_ERR   = 4'd10;
    localparam logic [3:0] ST_BUSY  = 4'd11;

    localparam logic signed [40:0] ACC_MAX = 41'sd549755813887;
    localparam logic signed [40:0] ACC_MIN = -41'sd549755813888;

    // Configuration registers.
    logic [4:0]  input_count_reg;
    logic [2:0]  layer_count_reg;
    logic [4:0]  size_reg [4];
    logic [15:0] bias_reg;
    logic [15:0] resp_reg;

    logic [3:0]  state_reg;
    logic [4:0]  rcount_reg;
    logic [1:0]  layer_reg;
    logic [2:0]  nlayers_reg;
    logic [3:0]  neuron_reg;
    logic [4:0]  size_cur_reg;
    logic [4:0]  fan_reg;
    logic [4:0]  slot_reg;
    logic signed [39:0] acc_reg;
    logic signed [31:0] prod_reg;
    logic signed [15:0] w_q;
    logic [15:0] a_q;
    logic        bias_step_reg;
    logic signed [55:0] scaled_reg;
    logic [7:0]  idx_reg;
    logic [15:0] sig_reg;
    logic [4:0]  ocnt_reg;
    logic [3:0]  oidx_reg;

    // Memories.
    logic [15:0] wmem [WMEM_DEPTH];
    logic [15:0] abuf [2*MAX_WIDTH];

    logic        s_fire;
    logic        op_in;
    logic [1:0]  in_layer;
    logic [3:0]  in_neuron;
    logic [4:0]  in_slot;

    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign op_in     = s_axis_tuser[0];
    assign in_layer  = s_axis_tuser[2:1];
    assign in_neuron = s_axis_tuser[6:3];
    assign in_slot   = s_axis_tuser[11:7];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;

    // Weight address during the walk.
    logic [WADDR_W-1:0] walk_addr;
    logic [WADDR_W-1:0] wr_addr;
    assign walk_addr = WADDR_W'((32'(layer_reg) * MAX_WIDTH + 32'(neuron_reg)) * SLOTS
                                + 32'(slot_reg));
    assign wr_addr   = WADDR_W'((32'(in_layer) * MAX_WIDTH + 32'(in_neuron)) * SLOTS
                                + 32'(in_slot));

    // Weight memory: written by weight items, read during the walk.
    always_ff @(posedge aclk) begin
        if (s_fire && op_in == OP_WEIGHT && in_slot <= 5'(MAX_WIDTH)) begin
            wmem[wr_addr] <= s_axis_tdata;
        end
        w_q <= wmem[walk_addr];
    end

    // Activation buffer: inputs go to bank 0, layer l writes bank (l+1)&1.
    logic [4:0] ab_rd_addr;
    logic [4:0] ab_wr_addr;
    logic       ab_we;
    logic [15:0] ab_wdata;
    always_comb begin
        ab_rd_addr = (state_reg == ST_OUTRD || state_reg == ST_OUT)
                   ? {nlayers_reg[0], oidx_reg} : {layer_reg[0], slot_reg[3:0]};
        ab_we      = 1'b0;
        ab_wr_addr = {1'b0, rcount_reg[3:0]};
        ab_wdata   = s_axis_tdata;
        if (s_fire && op_in == OP_INPUT && rcount_reg < 5'(MAX_WIDTH)) begin
            ab_we = 1'b1;
        end else if (state_reg == ST_WB) begin
            ab_we      = 1'b1;
            ab_wr_addr = {~layer_reg[0], neuron_reg};
            ab_wdata   = sig_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ab_we) begin
            abuf[ab_wr_addr] <= ab_wdata;
        end
        a_q <= abuf[ab_rd_addr];
    end

    // Clamped layer settings.
    function automatic logic [4:0] clamp_size(input logic [4:0] v);
        if (v == 5'd0) return 5'd1;
        if (v > 5'(MAX_WIDTH)) return 5'(MAX_WIDTH);
        return v;
    endfunction

    logic [2:0] nlayers_c;
    assign nlayers_c = (layer_count_reg == 3'd0) ? 3'd1
                     : (layer_count_reg > 3'(MAX_LAYERS)) ? 3'(MAX_LAYERS) : layer_count_reg;

    // Saturating add of the registered product.
    logic signed [40:0] sum_c;
    logic signed [39:0] sat_c;
    assign sum_c = 41'(acc_reg) + 41'(prod_reg);
    assign sat_c = (sum_c > ACC_MAX) ? ACC_MAX[39:0]
                 : (sum_c < ACC_MIN) ? ACC_MIN[39:0] : sum_c[39:0];

    // Product selection: input layer, hidden layer, or bias term.
    logic signed [31:0] prod_c;
    logic signed [32:0] hid_c;
    always_comb begin
        hid_c = w_q * $signed({1'b0, a_q});
        if (bias_step_reg) begin
            prod_c = w_q * $signed(bias_reg);
        end else if (layer_reg == 2'd0) begin
            prod_c = w_q * $signed(a_q);
        end else begin
            prod_c = 32'(hid_c >>> 4);
        end
    end

    // Scaled sum clamped to the table span and turned into an index.
    logic signed [55:0] z_c;
    logic signed [55:0] zc_c;
    logic [27:0]        zoff_c;
    assign z_c  = scaled_reg >>> 12;
    assign zc_c = (z_c < -56'sd134217728) ? -56'sd134217728
                : (z_c > 56'sd134217727) ? 56'sd134217727 : z_c;
    assign zoff_c = 28'(zc_c + 56'sd134217728);

    // The output register takes a new result when it is empty or draining.
    logic out_busy;
    logic out_load;
    assign out_busy = m_axis_tvalid && !m_axis_tready;
    assign out_load = (state_reg == ST_OUT || state_reg == ST_ERR) && !out_busy;

    // Control sequencer and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            rcount_reg      <= '0;
            acc_reg         <= '0;
            m_axis_tvalid   <= 1'b0;
            input_count_reg <= 5'd16;
            layer_count_reg <= 3'd2;
            size_reg[0]     <= 5'd16;
            size_reg[1]     <= 5'd4;
            size_reg[2]     <= 5'd1;
            size_reg[3]     <= 5'd1;
            bias_reg        <= 16'hF000;
            resp_reg        <= 16'd4096;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_INPUT_COUNT: input_count_reg <= cfg_data[4:0];
                    REG_LAYER_COUNT: layer_count_reg <= cfg_data[2:0];
                    REG_SIZE_0:      size_reg[0]     <= cfg_data[4:0];
                    REG_SIZE_1:      size_reg[1]     <= cfg_data[4:0];
                    REG_SIZE_2:      size_reg[2]     <= cfg_data[4:0];
                    REG_SIZE_3:      size_reg[3]     <= cfg_data[4:0];
                    REG_BIAS:        bias_reg        <= cfg_data;
                    REG_RESP_INV:    resp_reg        <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (op_in == OP_INPUT && s_axis_tlast) begin
                            rcount_reg <= '0;
                            if ((rcount_reg + 5'd1) != input_count_reg
                                || input_count_reg > 5'(MAX_WIDTH)) begin
                                state_reg <= ST_ERR;
                            end else begin
                                state_reg     <= ST_RD;
                                nlayers_reg   <= nlayers_c;
                                layer_reg     <= '0;
                                neuron_reg    <= '0;
                                slot_reg      <= '0;
                                fan_reg       <= input_count_reg;
                                size_cur_reg  <= clamp_size(size_reg[0]);
                                acc_reg       <= '0;
                                bias_step_reg <= (input_count_reg == 5'd0);
                            end
                        end else begin
                            state_reg <= ST_BUSY;
                            if (op_in == OP_INPUT && rcount_reg <= 5'(MAX_WIDTH)) begin
                                rcount_reg <= rcount_reg + 5'd1;
                            end
                        end
                    end
                end
                ST_BUSY: state_reg <= ST_IDLE;
                ST_RD:   state_reg <= ST_MUL;
                ST_MUL: begin
                    prod_reg  <= prod_c;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_reg <= sat_c;
                    if (bias_step_reg) begin
                        state_reg <= ST_SCALE;
                    end else begin
                        slot_reg      <= slot_reg + 5'd1;
                        bias_step_reg <= (slot_reg + 5'd1 == fan_reg);
                        state_reg     <= ST_RD;
                    end
                end
                ST_SCALE: begin
                    scaled_reg <= 56'(acc_reg) * $signed({1'b0, resp_reg});
                    state_reg  <= ST_ZSH;
                end
                ST_ZSH: begin
                    idx_reg   <= zoff_c[27:20];
                    state_reg <= ST_ROM;
                end
                ST_ROM: begin
                    sig_reg   <= SIG_ROM[idx_reg];
                    state_reg <= ST_WB;
                end
                ST_WB: begin
                    acc_reg  <= '0;
                    slot_reg <= '0;
                    if (5'(neuron_reg) + 5'd1 < size_cur_reg) begin
                        neuron_reg    <= neuron_reg + 4'd1;
                        bias_step_reg <= (fan_reg == 5'd0);
                        state_reg     <= ST_RD;
                    end else if (3'(layer_reg) + 3'd1 < nlayers_reg) begin
                        layer_reg     <= layer_reg + 2'd1;
                        neuron_reg    <= '0;
                        fan_reg       <= size_cur_reg;
                        size_cur_reg  <= clamp_size(size_reg[layer_reg + 2'd1]);
                        bias_step_reg <= 1'b0;
                        state_reg     <= ST_RD;
                    end else begin
                        ocnt_reg  <= size_cur_reg;
                        oidx_reg  <= '0;
                        state_reg <= ST_OUTRD;
                    end
                end
                ST_OUTRD: state_reg <= ST_OUT;
                ST_OUT: begin
                    if (!out_busy) begin
                        m_axis_tdata  <= {4'd0, oidx_reg, a_q};
                        m_axis_tuser  <= 1'b0;
                        m_axis_tlast  <= (5'(oidx_reg) + 5'd1 == ocnt_reg);
                        if (5'(oidx_reg) + 5'd1 == ocnt_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            oidx_reg  <= oidx_reg + 4'd1;
                            state_reg <= ST_OUTRD;
                        end
                    end
                end
                ST_ERR: begin
                    if (!out_busy) begin
                        m_axis_tdata  <= {4'd0, 4'd0, 16'd0};
                        m_axis_tuser  <= 1'b1;
                        m_axis_tlast  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // The sequencer only accepts items while idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    // A result is only loaded into an empty or draining output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result overwritten");
    // The input count never passes its saturation point.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rcount_reg <= 5'(MAX_WIDTH + 1))
        else $error("input count overflow");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import mlp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam longint ACC_MAX = (longint'(1) <<< 39) - 1;
    localparam longint ACC_MIN = -(longint'(1) <<< 39);
    localparam longint Z_HALF  = longint'(1) <<< 27;
    // Every topology below stays within four neurons and a fan-in of four.
    localparam int FILL_NEURONS = 4;
    localparam int FILL_SLOTS   = 5;

    typedef struct {
        logic        op;
        logic [1:0]  layer;
        logic [3:0]  neuron;
        logic [4:0]  slot;
        logic [15:0] value;
        logic        last;
        logic        typed_err;
    } stim_t;

    typedef struct {
        logic [15:0] value;
        logic [3:0]  idx;
        logic        last;
        logic        status;
    } activation_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [11:0] s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    mlp_sigmoid_inference dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Local copy of the network state and settings.
    logic [15:0] weights [WMEM_DEPTH];
    logic [15:0] act_bank [2 * MAX_WIDTH];
    logic [15:0] sig_lut [256];
    int          inputs_seen;
    logic [4:0]  n_inputs = 5'd16;
    logic [2:0]  n_layers = 3'd2;
    logic [4:0]  sizes [4] = '{5'd16, 5'd4, 5'd1, 5'd1};
    logic [15:0] bias_in = 16'hF000;
    logic [15:0] resp_inv = 16'd4096;

    activation_t awaited [$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int status_results = 0;
    int cycles = 0;
    bit quiet = 0;
    bit hold_req = 0;
    bit hold_done = 0;

    // exp(-t) in Q.31 for t in Q.24: short series on t/256, then squared eight times.
    function automatic logic [63:0] decay_q31(input logic [63:0] t);
        logic [63:0] h;
        logic [63:0] h2;
        logic [63:0] h3;
        logic [63:0] h4;
        logic [63:0] acc;
        h   = t >> 1;
        h2  = (h * h) >> 31;
        h3  = (h2 * h) >> 31;
        h4  = (h3 * h) >> 31;
        acc = (64'd1 << 31) - h + h2 / 64'd2 - h3 / 64'd6 + h4 / 64'd24;
        repeat (8) acc = (acc * acc) >> 31;
        return acc;
    endfunction

    function automatic longint sat40(input longint v);
        if (v > ACC_MAX) return ACC_MAX;
        if (v < ACC_MIN) return ACC_MIN;
        return v;
    endfunction

    function automatic logic [15:0] squash(input longint z);
        longint zc;
        zc = z < -Z_HALF ? -Z_HALF : (z > Z_HALF - 1 ? Z_HALF - 1 : z);
        return sig_lut[int'((zc + Z_HALF) >>> 20)];
    endfunction

    function automatic int clampi(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Apply one accepted item; any results it produces go to outs.
    function automatic void network_step(input stim_t it, ref activation_t outs [$]);
        int n;
        int layers;
        int fan;
        int size;
        int src;
        int dst;
        int base;
        longint acc;
        longint w;
        longint p;
        activation_t r;
        if (it.op == OP_WEIGHT) begin
            if (it.slot <= MAX_WIDTH)
                weights[(it.layer * MAX_WIDTH + it.neuron) * SLOTS + it.slot] = it.value;
            return;
        end
        if (inputs_seen < MAX_WIDTH) act_bank[inputs_seen] = it.value;
        if (inputs_seen <= MAX_WIDTH) inputs_seen++;
        if (!it.last) return;
        n = inputs_seen;
        inputs_seen = 0;
        if (n != n_inputs || n > MAX_WIDTH) begin
            r = '{16'd0, 4'd0, 1'b1, 1'b1};
            outs.push_back(r);
            return;
        end
        layers = clampi(n_layers, 1, MAX_LAYERS);
        fan = n;
        for (int l = 0; l < layers; l++) begin
            size = clampi(sizes[l], 1, MAX_WIDTH);
            src = (l & 1) * MAX_WIDTH;
            dst = ((l + 1) & 1) * MAX_WIDTH;
            for (int k = 0; k < size; k++) begin
                base = (l * MAX_WIDTH + k) * SLOTS;
                acc = 0;
                for (int s = 0; s < fan; s++) begin
                    w = longint'($signed(weights[base + s]));
                    if (l == 0) p = w * longint'($signed(act_bank[src + s]));
                    else p = (w * longint'(act_bank[src + s])) >>> 4;
                    acc = sat40(acc + p);
                end
                w = longint'($signed(weights[base + fan]));
                acc = sat40(acc + w * longint'($signed(bias_in)));
                act_bank[dst + k] = squash((acc * longint'(resp_inv)) >>> 12);
            end
            fan = size;
        end
        for (int k = 0; k < fan; k++) begin
            r.value = act_bank[(layers & 1) * MAX_WIDTH + k];
            r.idx = k[3:0];
            r.last = (k + 1 == fan);
            r.status = 1'b0;
            outs.push_back(r);
        end
    endfunction

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 16'h2000) - 16'h1000);
        endcase
    endfunction

    // Offer one item; an optional idle burst comes first.
    task automatic send_item(input stim_t it);
        activation_t outs [$];
        if (!quiet && $urandom_range(0, 4) == 0) begin
            @(negedge aclk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = it.value;
        s_axis_tuser = {it.slot, it.neuron, it.layer, it.op};
        s_axis_tlast = it.last;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
        network_step(it, outs);
        if (it.typed_err) awaited.push_back('{16'd0, 4'd0, 1'b1, 1'b1});
        else foreach (outs[i]) awaited.push_back(outs[i]);
    endtask

    task automatic end_stream();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_INPUT_COUNT: n_inputs = data[4:0];
            REG_LAYER_COUNT: n_layers = data[2:0];
            REG_SIZE_0:      sizes[0] = data[4:0];
            REG_SIZE_1:      sizes[1] = data[4:0];
            REG_SIZE_2:      sizes[2] = data[4:0];
            REG_SIZE_3:      sizes[3] = data[4:0];
            REG_BIAS:        bias_in = data;
            REG_RESP_INV:    resp_inv = data;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Let every expected result drain, then allow trailing item work to settle.
    task automatic drain(input int settle);
        while (awaited.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    function automatic stim_t weight_item(input int l, input int n, input int s,
                                          input logic [15:0] v);
        stim_t it;
        it = '{OP_WEIGHT, 2'(l), 4'(n), 5'(s), v, 1'($urandom), 1'b0};
        return it;
    endfunction

    function automatic stim_t input_item(input logic [15:0] v, input logic last);
        stim_t it;
        it = '{OP_INPUT, 2'($urandom), 4'($urandom), 5'($urandom), v, last, 1'b0};
        return it;
    endfunction

    // Random traffic: mostly complete vectors, some weight updates and broken vectors.
    task automatic random_phase(input int target);
        int start;
        int len;
        int pick;
        start = items_sent;
        while (items_sent - start < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                send_item(weight_item($urandom_range(0, 3), $urandom_range(0, 15),
                                      $urandom_range(0, 31), rand_value()));
            end else begin
                if (pick < 25 || n_inputs == 0 || n_inputs > MAX_WIDTH)
                    len = $urandom_range(1, 18);
                else
                    len = n_inputs;
                for (int i = 0; i < len; i++)
                    send_item(input_item(rand_value(), i == len - 1));
            end
        end
        end_stream();
    endtask

    // Result checker.
    always @(posedge aclk) begin
        activation_t exp_r;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tuser) status_results++;
            if (results_seen == 5 && !hold_done) hold_req <= 1'b1;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h status %b last %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                exp_r = awaited.pop_front();
                if (m_axis_tdata[15:0] !== exp_r.value || m_axis_tdata[19:16] !== exp_r.idx
                    || m_axis_tuser !== exp_r.status || m_axis_tlast !== exp_r.last) begin
                    errors++;
                    $display("%0t: mismatch, expected value %h index %0d status %b last %b,",
                             $time, exp_r.value, exp_r.idx, exp_r.status, exp_r.last);
                    $display("    actual value %h index %0d status %b last %b",
                             m_axis_tdata[15:0], m_axis_tdata[19:16], m_axis_tuser,
                             m_axis_tlast);
                end
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_axis_tready = 1'b0;
                for (int c = 0; c < 400; c++) @(negedge aclk);
                hold_done = 1'b1;
                m_axis_tready = 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge aclk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        stim_t plan [$];
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] r;
        longint zi;

        // Sigmoid table, one entry per 1/16 step of z over [-8, 8).
        for (int i = 0; i < 256; i++) begin
            zi = -Z_HALF + longint'(i) * (longint'(1) <<< 20);
            t = (zi < 0) ? 64'(-zi) : 64'(zi);
            e = decay_q31(t);
            d = (64'd1 << 31) + e;
            if (zi >= 0) r = ((64'd1 << 47) + d / 64'd2) / d;
            else r = ((e << 16) + d / 64'd2) / d;
            sig_lut[i] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
        end
        inputs_seen = 0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Fill every weight the topologies below can reach, so none is read unwritten.
        for (int l = 0; l < MAX_LAYERS; l++)
            for (int n = 0; n < FILL_NEURONS; n++)
                for (int s = 0; s < FILL_SLOTS; s++)
                    send_item(weight_item(l, n, s, rand_value()));
        end_stream();

        // Directed rows under the reset settings (16 inputs expected).
        plan.push_back('{OP_WEIGHT, 2'd3, 4'd15, 5'd16, 16'h7FFF, 1'b0, 1'b0});
        plan.push_back('{OP_WEIGHT, 2'd0, 4'd0, 5'd16, 16'h8000, 1'b1, 1'b0});
        plan.push_back('{OP_WEIGHT, 2'd0, 4'd0, 5'd17, 16'h1234, 1'b1, 1'b0});
        plan.push_back('{OP_WEIGHT, 2'd1, 4'd3, 5'd31, 16'hFFFF, 1'b0, 1'b0});
        plan.push_back('{OP_WEIGHT, 2'd1, 4'd0, 5'd0, 16'h0000, 1'b0, 1'b0});
        // A one-item vector is short of the count and must give a status result.
        plan.push_back('{OP_INPUT, 2'd0, 4'd0, 5'd0, 16'h7FFF, 1'b1, 1'b1});
        // Seventeen inputs overrun the count, which saturates; again a status result.
        for (int i = 0; i < 17; i++) begin
            plan.push_back('{OP_INPUT, 2'd0, 4'd0, 5'd0,
                             i == 0 ? 16'h8000 : i == 1 ? 16'h7FFF : i == 2 ? 16'h0000 :
                             i == 3 ? 16'hFFFF : rand_value(), i == 16, i == 16});
        end
        foreach (plan[i]) send_item(plan[i]);
        end_stream();

        // Phases of settings; registers change only with the block idle.
        for (int ph = 0; ph < 5; ph++) begin
            drain(50);
            case (ph)
                0: begin
                    write_reg(REG_INPUT_COUNT, 16'd1);
                    write_reg(REG_LAYER_COUNT, 16'd1);
                    write_reg(REG_SIZE_0, 16'd1);
                    write_reg(REG_SIZE_1, 16'd1);
                    write_reg(REG_SIZE_2, 16'd1);
                    write_reg(REG_SIZE_3, 16'd1);
                    write_reg(REG_BIAS, 16'h7FFF);
                    write_reg(REG_RESP_INV, 16'hFFFF);
                    random_phase(12);
                end
                1: begin
                    write_reg(REG_INPUT_COUNT, 16'd4);
                    write_reg(REG_LAYER_COUNT, 16'd4);
                    write_reg(REG_SIZE_0, 16'd4);
                    write_reg(REG_SIZE_1, 16'd4);
                    write_reg(REG_SIZE_2, 16'd4);
                    write_reg(REG_SIZE_3, 16'd4);
                    write_reg(REG_BIAS, 16'h8000);
                    write_reg(REG_RESP_INV, 16'd1);
                    random_phase(12);
                end
                2: begin
                    write_reg(REG_INPUT_COUNT, 16'd4);
                    write_reg(REG_LAYER_COUNT, 16'd0);
                    write_reg(REG_SIZE_0, 16'd0);
                    write_reg(REG_SIZE_1, 16'd31);
                    write_reg(REG_BIAS, 16'd0);
                    write_reg(REG_RESP_INV, 16'd0);
                    random_phase(10);
                end
                3: begin
                    write_reg(REG_INPUT_COUNT, 16'd17);
                    write_reg(REG_LAYER_COUNT, 16'd3);
                    write_reg(REG_SIZE_0, 16'd31);
                    write_reg(REG_SIZE_1, 16'd2);
                    write_reg(REG_SIZE_2, 16'd3);
                    write_reg(REG_RESP_INV, 16'd4096);
                    random_phase(6);
                end
                default: begin
                    // Final phase runs without idling on either side.
                    quiet = 1;
                    write_reg(REG_INPUT_COUNT, 16'd3);
                    write_reg(REG_LAYER_COUNT, 16'd7);
                    write_reg(REG_SIZE_0, 16'd3);
                    write_reg(REG_SIZE_1, 16'd4);
                    write_reg(REG_SIZE_2, 16'd2);
                    write_reg(REG_SIZE_3, 16'd4);
                    write_reg(REG_BIAS, 16'($urandom));
                    write_reg(REG_RESP_INV, 16'd4096);
                    random_phase(12);
                end
            endcase
        end

        drain(200);
        $display("Sent %0d items over five settings plus reset values; checked %0d results,",
                 items_sent, results_seen);
        $display("%0d of them count-mismatch status results.", status_results);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
